// File: src/s2y_pkg.sv
`default_nettype none

package s2y_pkg;

    localparam int IN_FRAC = 14;
    localparam int OUT_FRAC = 16;
    localparam int DEF_IN_WIDTH = 20;
    localparam int DEF_OUT_WIDTH = 32;

    function automatic int imax(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

endpackage

`default_nettype wire

// File: src/s2y_s_if.sv
`default_nettype none

interface s2y_s_if
    import s2y_pkg::*;
#(
    parameter int IN_WIDTH = DEF_IN_WIDTH
);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] s11_re;
    logic signed [IN_WIDTH-1:0] s11_im;
    logic signed [IN_WIDTH-1:0] s12_re;
    logic signed [IN_WIDTH-1:0] s12_im;
    logic signed [IN_WIDTH-1:0] s21_re;
    logic signed [IN_WIDTH-1:0] s21_im;
    logic signed [IN_WIDTH-1:0] s22_re;
    logic signed [IN_WIDTH-1:0] s22_im;

    modport source (
        output valid, s11_re, s11_im, s12_re, s12_im, s21_re, s21_im, s22_re, s22_im,
        input  ready
    );
    modport sink (
        input  valid, s11_re, s11_im, s12_re, s12_im, s21_re, s21_im, s22_re, s22_im,
        output ready
    );
endinterface

`default_nettype wire

// File: src/s2y_y_if.sv
`default_nettype none

interface s2y_y_if
    import s2y_pkg::*;
#(
    parameter int OUT_WIDTH = DEF_OUT_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] y11_re;
    logic signed [OUT_WIDTH-1:0] y11_im;
    logic signed [OUT_WIDTH-1:0] y12_re;
    logic signed [OUT_WIDTH-1:0] y12_im;
    logic signed [OUT_WIDTH-1:0] y21_re;
    logic signed [OUT_WIDTH-1:0] y21_im;
    logic signed [OUT_WIDTH-1:0] y22_re;
    logic signed [OUT_WIDTH-1:0] y22_im;
    logic                        range_error;

    modport source (
        output valid, y11_re, y11_im, y12_re, y12_im, y21_re, y21_im, y22_re, y22_im,
        output range_error,
        input  ready
    );
    modport sink (
        input  valid, y11_re, y11_im, y12_re, y12_im, y21_re, y21_im, y22_re, y22_im,
        input  range_error,
        output ready
    );
endinterface

`default_nettype wire

// File: src/two_port_s_to_y_convert.sv
// S to Y parameter conversion for a two-port, Z0 = 1. One frequency point per
// transaction: S11, S12, S21, S22 as signed Q6.14 parts in, the eight parts of
// Y11, Y12, Y21, Y22 as signed Q16.16 out, rounded to nearest (halves away from
// zero) and saturated, with range_error set on a zero denominator (all parts 0)
// or on any saturation. A new point is taken every cycle while the output skid
// buffer is empty. The eight restoring dividers resolve one quotient bit per
// pipeline stage. A one-entry skid buffer at the output catches the result
// when the receiver stalls; the whole pipeline and the input then hold until
// that result is taken.
`default_nettype none

module two_port_s_to_y_convert
    import s2y_pkg::*;
#(
    parameter int IN_WIDTH  = DEF_IN_WIDTH,
    parameter int OUT_WIDTH = DEF_OUT_WIDTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    s2y_s_if.sink     s_ch,
    s2y_y_if.source   y_ch
);
    localparam int W  = IN_WIDTH;
    localparam int EW = imax(W, IN_FRAC + 2);
    localparam int AW = EW + 1;
    localparam int PW = 2 * AW;
    localparam int NW = PW + 2;
    localparam int DW = 2 * NW;
    localparam int CW = 2 * NW + 1;
    localparam int NS = OUT_WIDTH + 9;
    localparam logic signed [AW-1:0] ONE_A = AW'(1) << IN_FRAC;

    logic          en;
    logic [NS-1:0] v_reg;

    // stage 0: one plus / one minus the reflections
    logic signed [AW-1:0] a_re_reg, a_im_reg, b_re_reg, b_im_reg;
    logic signed [AW-1:0] c_re_reg, c_im_reg, d_re_reg, d_im_reg;
    logic signed [W-1:0]  s12r_reg, s12i_reg, s21r_reg, s21i_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_re_reg <= ONE_A + AW'(s_ch.s11_re);
            a_im_reg <= AW'(s_ch.s11_im);
            b_re_reg <= ONE_A + AW'(s_ch.s22_re);
            b_im_reg <= AW'(s_ch.s22_im);
            c_re_reg <= ONE_A - AW'(s_ch.s11_re);
            c_im_reg <= -AW'(s_ch.s11_im);
            d_re_reg <= ONE_A - AW'(s_ch.s22_re);
            d_im_reg <= -AW'(s_ch.s22_im);
            s12r_reg <= s_ch.s12_re;
            s12i_reg <= s_ch.s12_im;
            s21r_reg <= s_ch.s21_re;
            s21i_reg <= s_ch.s21_im;
        end
    end

    // stage 1: real partial products of a*b, c*b, a*d and s12*s21
    logic signed [AW-1:0]   xr [3];
    logic signed [AW-1:0]   xi [3];
    logic signed [AW-1:0]   yr [3];
    logic signed [AW-1:0]   yi [3];
    logic signed [PW-1:0]   rr_reg [3];
    logic signed [PW-1:0]   ii_reg [3];
    logic signed [PW-1:0]   ri_reg [3];
    logic signed [PW-1:0]   ir_reg [3];
    logic signed [2*W-1:0]  prr, pii, pri, pir;
    logic signed [PW-1:0]   prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [W-1:0]    s12r_d_reg, s12i_d_reg, s21r_d_reg, s21i_d_reg;

    assign xr[0] = a_re_reg;
    assign xi[0] = a_im_reg;
    assign yr[0] = b_re_reg;
    assign yi[0] = b_im_reg;
    assign xr[1] = c_re_reg;
    assign xi[1] = c_im_reg;
    assign yr[1] = b_re_reg;
    assign yi[1] = b_im_reg;
    assign xr[2] = a_re_reg;
    assign xi[2] = a_im_reg;
    assign yr[2] = d_re_reg;
    assign yi[2] = d_im_reg;

    assign prr = s12r_reg * s21r_reg;
    assign pii = s12i_reg * s21i_reg;
    assign pri = s12r_reg * s21i_reg;
    assign pir = s12i_reg * s21r_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_cmul
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rr_reg[k] <= xr[k] * yr[k];
                ii_reg[k] <= xi[k] * yi[k];
                ri_reg[k] <= xr[k] * yi[k];
                ir_reg[k] <= xi[k] * yr[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prr_reg    <= PW'(prr);
            pii_reg    <= PW'(pii);
            pri_reg    <= PW'(pri);
            pir_reg    <= PW'(pir);
            s12r_d_reg <= s12r_reg;
            s12i_d_reg <= s12i_reg;
            s21r_d_reg <= s21r_reg;
            s21i_d_reg <= s21i_reg;
        end
    end

    // stage 2: denominator and the four numerators
    logic signed [NW-1:0] p_re, p_im;
    logic signed [NW-1:0] cp_re [3];
    logic signed [NW-1:0] cp_im [3];
    logic signed [NW-1:0] dr_reg, di_reg;
    logic signed [NW-1:0] nr_reg [4];
    logic signed [NW-1:0] ni_reg [4];

    assign p_re = NW'(prr_reg) - NW'(pii_reg);
    assign p_im = NW'(pri_reg) + NW'(pir_reg);

    for (genvar k = 0; k < 3; k++)
    begin : g_csum
        assign cp_re[k] = NW'(rr_reg[k]) - NW'(ii_reg[k]);
        assign cp_im[k] = NW'(ri_reg[k]) + NW'(ir_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dr_reg    <= cp_re[0] - p_re;
            di_reg    <= cp_im[0] - p_im;
            nr_reg[0] <= cp_re[1] + p_re;
            ni_reg[0] <= cp_im[1] + p_im;
            nr_reg[1] <= -(NW'(s12r_d_reg) <<< (IN_FRAC + 1));
            ni_reg[1] <= -(NW'(s12i_d_reg) <<< (IN_FRAC + 1));
            nr_reg[2] <= -(NW'(s21r_d_reg) <<< (IN_FRAC + 1));
            ni_reg[2] <= -(NW'(s21i_d_reg) <<< (IN_FRAC + 1));
            nr_reg[3] <= cp_re[2] + p_re;
            ni_reg[3] <= cp_im[2] + p_im;
        end
    end

    // stages 3 and 4: wide products against the conjugate denominator
    logic signed [DW-1:0] den_rr, den_ii;
    logic signed [DW-1:0] m_rr [4];
    logic signed [DW-1:0] m_ii [4];
    logic signed [DW-1:0] m_ir [4];
    logic signed [DW-1:0] m_ri [4];

    s2y_wmul #(.NW(NW)) u_den_rr (.clk(clk), .en(en), .a(dr_reg), .b(dr_reg), .p(den_rr));
    s2y_wmul #(.NW(NW)) u_den_ii (.clk(clk), .en(en), .a(di_reg), .b(di_reg), .p(den_ii));

    for (genvar k = 0; k < 4; k++)
    begin : g_wmul
        s2y_wmul #(.NW(NW)) u_rr (.clk(clk), .en(en), .a(nr_reg[k]), .b(dr_reg), .p(m_rr[k]));
        s2y_wmul #(.NW(NW)) u_ii (.clk(clk), .en(en), .a(ni_reg[k]), .b(di_reg), .p(m_ii[k]));
        s2y_wmul #(.NW(NW)) u_ir (.clk(clk), .en(en), .a(ni_reg[k]), .b(dr_reg), .p(m_ir[k]));
        s2y_wmul #(.NW(NW)) u_ri (.clk(clk), .en(en), .a(nr_reg[k]), .b(di_reg), .p(m_ri[k]));
    end

    // stage 5: |D|^2 and the numerators times conj(D)
    logic signed [CW-1:0] den_sum;
    logic [DW-1:0]        den_reg;
    logic                 dz_reg;
    logic signed [CW-1:0] re_reg [4];
    logic signed [CW-1:0] im_reg [4];

    assign den_sum = CW'(den_rr) + CW'(den_ii);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_sum[DW-1:0];
            dz_reg  <= (den_sum == '0);
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_comb
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                re_reg[k] <= CW'(m_rr[k]) + CW'(m_ii[k]);
                im_reg[k] <= CW'(m_ir[k]) - CW'(m_ri[k]);
            end
        end
    end

    // stages 6 on: one divider lane per output part
    logic signed [OUT_WIDTH-1:0] lane_y [8];
    logic [7:0]                  lane_err;

    for (genvar j = 0; j < 8; j++)
    begin : g_lane
        s2y_lane #(
            .NUM_W    (CW),
            .DEN_W    (DW),
            .OUT_WIDTH(OUT_WIDTH)
        ) u_lane (
            .clk(clk),
            .en (en),
            .num((j % 2 == 1) ? im_reg[j/2] : re_reg[j/2]),
            .den(den_reg),
            .dz (dz_reg),
            .y  (lane_y[j]),
            .err(lane_err[j])
        );
    end

    // valid bits and output skid
    logic                        skid_v_reg;
    logic signed [OUT_WIDTH-1:0] skid_y_reg [8];
    logic                        skid_err_reg;
    logic signed [OUT_WIDTH-1:0] out_y [8];

    assign en         = !skid_v_reg;
    assign s_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v_reg <= {v_reg[NS-2:0], s_ch.valid};
            end
            if (!skid_v_reg)
            begin
                skid_v_reg <= v_reg[NS-1] && !y_ch.ready;
            end
            else if (y_ch.ready)
            begin
                skid_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            skid_y_reg   <= lane_y;
            skid_err_reg <= |lane_err;
        end
    end

    for (genvar j = 0; j < 8; j++)
    begin : g_out
        assign out_y[j] = skid_v_reg ? skid_y_reg[j] : lane_y[j];
    end

    assign y_ch.valid       = skid_v_reg || v_reg[NS-1];
    assign y_ch.range_error = skid_v_reg ? skid_err_reg : |lane_err;
    assign y_ch.y11_re      = out_y[0];
    assign y_ch.y11_im      = out_y[1];
    assign y_ch.y12_re      = out_y[2];
    assign y_ch.y12_im      = out_y[3];
    assign y_ch.y21_re      = out_y[4];
    assign y_ch.y21_im      = out_y[5];
    assign y_ch.y22_re      = out_y[6];
    assign y_ch.y22_im      = out_y[7];
endmodule

`default_nettype wire

// File: src/s2y_wmul.sv
`default_nettype none

module s2y_wmul #(
    parameter int NW = 44
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic signed [NW-1:0]   a,
    input  wire logic signed [NW-1:0]   b,
    output logic signed [2*NW-1:0]      p
);
    localparam int H  = NW / 2;
    localparam int HW = NW - H;
    localparam int PW = 2 * NW;

    logic signed [HW-1:0]     ah;
    logic signed [HW-1:0]     bh;
    logic signed [H:0]        al;
    logic signed [H:0]        bl;
    logic signed [2*HW-1:0]   hh_reg;
    logic signed [HW+H:0]     hl_reg;
    logic signed [HW+H:0]     lh_reg;
    logic signed [2*H+1:0]    ll_reg;
    logic signed [PW-1:0]     p_next;
    logic signed [PW-1:0]     p_reg;

    // split into signed high and unsigned low halves
    assign ah = a[NW-1:H];
    assign bh = b[NW-1:H];
    assign al = $signed({1'b0, a[H-1:0]});
    assign bl = $signed({1'b0, b[H-1:0]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= ah * bh;
            hl_reg <= ah * bl;
            lh_reg <= al * bh;
            ll_reg <= al * bl;
        end
    end

    assign p_next = (PW'(hh_reg) <<< (2 * H))
                  + ((PW'(hl_reg) + PW'(lh_reg)) <<< H)
                  + PW'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;
endmodule

`default_nettype wire

// File: src/s2y_lane.sv
`default_nettype none

module s2y_lane
    import s2y_pkg::*;
#(
    parameter int NUM_W     = 89,
    parameter int DEN_W     = 88,
    parameter int OUT_WIDTH = DEF_OUT_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]         den,
    input  wire logic                     dz,
    output logic signed [OUT_WIDTH-1:0]   y,
    output logic                          err
);
    localparam int MW  = NUM_W + OUT_FRAC + 2;
    localparam int XW  = imax(MW, DEN_W + 1 + OUT_WIDTH);
    localparam int D2W = DEN_W + 1;
    localparam logic [OUT_WIDTH-1:0] HALF = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    logic [NUM_W-1:0]     mag;
    logic [XW-1:0]        m_next;
    logic [XW-1:0]        m_reg;
    logic [D2W-1:0]       d2_reg;
    logic                 neg_reg;
    logic                 dz_reg;

    logic [XW-1:0]        r_reg   [OUT_WIDTH+1];
    logic [D2W-1:0]       d2s_reg [OUT_WIDTH+1];
    logic [OUT_WIDTH-1:0] q_reg   [OUT_WIDTH+1];
    logic                 negs_reg[OUT_WIDTH+1];
    logic                 dzs_reg [OUT_WIDTH+1];
    logic                 ovf_reg [OUT_WIDTH+1];

    logic [OUT_WIDTH-1:0] lim;
    logic                 over;
    logic [OUT_WIDTH-1:0] qmag;
    logic [OUT_WIDTH-1:0] y_next;
    logic [OUT_WIDTH-1:0] y_reg;
    logic                 err_reg;

    // rounded quotient is floor((2|n|*2^f + den) / (2 den))
    assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign m_next = (XW'(mag) << (OUT_FRAC + 1)) + XW'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg   <= m_next;
            d2_reg  <= {den, 1'b0};
            neg_reg <= num[NUM_W-1];
            dz_reg  <= dz;
        end
    end

    // quotient that cannot fit the output width is flagged up front
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= m_reg;
            d2s_reg[0]  <= d2_reg;
            q_reg[0]    <= '0;
            negs_reg[0] <= neg_reg;
            dzs_reg[0]  <= dz_reg;
            ovf_reg[0]  <= (m_reg >= (XW'(d2_reg) << OUT_WIDTH));
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar j = 0; j < OUT_WIDTH; j++)
    begin : g_div
        localparam int K = OUT_WIDTH - 1 - j;
        logic [XW:0] diff;
        logic        take;

        assign diff = {1'b0, r_reg[j]} - {1'b0, (XW'(d2s_reg[j]) << K)};
        assign take = !diff[XW];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j+1]    <= take ? diff[XW-1:0] : r_reg[j];
                q_reg[j+1]    <= {q_reg[j][OUT_WIDTH-2:0], take};
                d2s_reg[j+1]  <= d2s_reg[j];
                negs_reg[j+1] <= negs_reg[j];
                dzs_reg[j+1]  <= dzs_reg[j];
                ovf_reg[j+1]  <= ovf_reg[j];
            end
        end
    end

    assign lim  = negs_reg[OUT_WIDTH] ? HALF : HALF - OUT_WIDTH'(1);
    assign over = ovf_reg[OUT_WIDTH] || (q_reg[OUT_WIDTH] > lim);
    assign qmag = over ? lim : q_reg[OUT_WIDTH];

    always_comb
    begin
        if (dzs_reg[OUT_WIDTH])
        begin
            y_next = '0;
        end
        else if (negs_reg[OUT_WIDTH])
        begin
            y_next = -qmag;
        end
        else
        begin
            y_next = qmag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg   <= y_next;
            err_reg <= over || dzs_reg[OUT_WIDTH];
        end
    end

    assign y   = $signed(y_reg);
    assign err = err_reg;
endmodule

`default_nettype wire

// File: src/s2y_chk.sv
`default_nettype none

module s2y_chk
    import s2y_pkg::*;
#(
    parameter int OUT_WIDTH = DEF_OUT_WIDTH
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 y_valid,
    input wire logic                 y_ready,
    input wire logic [OUT_WIDTH-1:0] y11_re,
    input wire logic                 range_error
);
    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;

    // transactions taken in but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg;
        if (s_valid && s_ready)
        begin
            cnt_next = cnt_next + 8'd1;
        end
        if (y_valid && y_ready)
        begin
            cnt_next = cnt_next - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !y_valid |-> s_ready)
        else $error("input stalled with no result waiting");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        y_valid |-> cnt_reg != 8'd0)
        else $error("result shown with no transaction in flight");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        y_valid && !y_ready |=> y_valid && $stable(y11_re) && $stable(range_error))
        else $error("stalled result changed");
endmodule

bind two_port_s_to_y_convert s2y_chk #(
    .OUT_WIDTH(OUT_WIDTH)
) u_s2y_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (s_ch.valid),
    .s_ready    (s_ch.ready),
    .y_valid    (y_ch.valid),
    .y_ready    (y_ch.ready),
    .y11_re     (y_ch.y11_re),
    .range_error(y_ch.range_error)
);

`default_nettype wire
